// ===== hw/rtl/oapm_pkg.sv =====
`default_nettype none
package oapm_pkg;

  // Width of the load-order index carried with every stored anchor.
  localparam int unsigned ORIG_W = 7;
  // Width of the normal components and of the distance tolerance.
  localparam int unsigned NORM_W = 16;
  localparam int unsigned MDIST_W = 23;
  localparam int unsigned EPS2_W = 2 * MDIST_W;
  // Squared distance width, and the value used for far-apart candidates.
  localparam int unsigned DIST_W = 63;
  localparam logic [DIST_W-1:0] DIST_CAP = 63'h4000_0000_0000_0000;
  // Opposed normals: dot product in Q2.28 must be below -0.9.
  localparam logic signed [33:0] DOT_NEG_LIMIT = -34'sd241591904;
  // Register address of match_distance.
  localparam logic [1:0] ADDR_MATCH_DIST = 2'd0;
  localparam logic [MDIST_W-1:0] MDIST_RESET = 23'd256;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_JREAD,
    ST_JWAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SWAP_RA,
    ST_SWAP_RB,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_J,
    RD_I,
    RD_BEST,
    RD_LAST
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_A,
    WR_B
  } wr_sel_e;

  typedef struct packed {
    logic    in_ready;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    scan_issue;
    logic    j_latch;
    logic    j_inc;
    logic    swap_latch;
    logic    live_dec;
    logic    take_pair;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic in_last_acc;
    logic j_end;
    logic i_end;
    logic pipe_busy;
    logic hit;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/opposed_anchor_pair_matcher_unit.sv =====
`default_nettype none
// Channel  | Direction | Payload
// s_axis   | in        | tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z; tlast: last_anchor
// m_axis   | out       | tdata: anchor_a, anchor_b, pair_valid; tlast: last
// apb      | in/out    | register 0 at address 0: match_distance
//
// Anchors load at one per cycle. After the last anchor the match scans, per slot j, the
// candidates through the single read port and the distance pipeline, and swaps slots
// for each accepted pair.
// Reset clears the controller, counters and handshake state; the store needs no clearing.
// A stalled output holds the match at the next pair; input is taken only while loading.
module opposed_anchor_pair_matcher_unit #(
  parameter int unsigned ANCHORS  = 128,
  parameter int unsigned POS_BITS = 24
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: pos_x[23:0], pos_y[47:24], pos_z[71:48],
  // norm_x[87:72], norm_y[103:88], norm_z[119:104].
  input  wire [119:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // Fields from bit 0: anchor_a[6:0], anchor_b[13:7], pair_valid[14], zero[15].
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  oapm_pkg::cmd_t    cmd;
  oapm_pkg::status_t sts;

  logic [oapm_pkg::MDIST_W-1:0] mdist_q;
  logic [oapm_pkg::EPS2_W-1:0]  eps2_q;

  // Configuration register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdist_q <= oapm_pkg::MDIST_RESET;
    end else if (psel && penable && pwrite && (paddr == oapm_pkg::ADDR_MATCH_DIST)) begin
      mdist_q <= pwdata[oapm_pkg::MDIST_W-1:0];
    end
  end

  // Squared tolerance, kept registered.
  always_ff @(posedge clk_i) begin
    eps2_q <= oapm_pkg::EPS2_W'(mdist_q) * oapm_pkg::EPS2_W'(mdist_q);
  end

  assign pready = 1'b1;
  assign prdata = (paddr == oapm_pkg::ADDR_MATCH_DIST) ? 32'(mdist_q) : 32'd0;
  assign s_axis_tready = cmd.in_ready;

  oapm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oapm_datapath #(
    .ANCHORS  (ANCHORS),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .eps2_i      (eps2_q),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/oapm_ctrl.sv =====
`default_nettype none
module oapm_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  oapm_pkg::status_t sts_i,
  output oapm_pkg::cmd_t    cmd_o
);

  oapm_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oapm_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oapm_pkg::ST_LOAD: begin
        if (sts_i.in_last_acc) state_d = oapm_pkg::ST_JREAD;
      end
      oapm_pkg::ST_JREAD: begin
        state_d = sts_i.j_end ? oapm_pkg::ST_FINISH : oapm_pkg::ST_JWAIT;
      end
      oapm_pkg::ST_JWAIT: state_d = oapm_pkg::ST_SCAN;
      oapm_pkg::ST_SCAN: begin
        if (sts_i.i_end) state_d = oapm_pkg::ST_DRAIN;
      end
      oapm_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = oapm_pkg::ST_DECIDE;
      end
      oapm_pkg::ST_DECIDE: begin
        if (!sts_i.hit) begin
          state_d = oapm_pkg::ST_JREAD;
        end else if (!sts_i.out_full) begin
          state_d = oapm_pkg::ST_SWAP_RA;
        end
      end
      oapm_pkg::ST_SWAP_RA: state_d = oapm_pkg::ST_SWAP_RB;
      oapm_pkg::ST_SWAP_RB: state_d = oapm_pkg::ST_SWAP_WA;
      oapm_pkg::ST_SWAP_WA: state_d = oapm_pkg::ST_SWAP_WB;
      oapm_pkg::ST_SWAP_WB: state_d = oapm_pkg::ST_JREAD;
      oapm_pkg::ST_FINISH: begin
        if (!sts_i.out_full) state_d = oapm_pkg::ST_LOAD;
      end
      default: state_d = oapm_pkg::ST_LOAD;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = oapm_pkg::RD_J;
    cmd_o.wr_sel = oapm_pkg::WR_NONE;
    unique case (state_q)
      oapm_pkg::ST_LOAD: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.wr_sel = oapm_pkg::WR_LOAD;
      end
      oapm_pkg::ST_JREAD: cmd_o.rd_sel = oapm_pkg::RD_J;
      oapm_pkg::ST_JWAIT: cmd_o.j_latch = 1'b1;
      oapm_pkg::ST_SCAN: begin
        cmd_o.rd_sel = oapm_pkg::RD_I;
        cmd_o.scan_issue = 1'b1;
      end
      oapm_pkg::ST_DRAIN: cmd_o.rd_sel = oapm_pkg::RD_I;
      oapm_pkg::ST_DECIDE: begin
        cmd_o.j_inc = !sts_i.hit;
        cmd_o.take_pair = sts_i.hit && !sts_i.out_full;
      end
      oapm_pkg::ST_SWAP_RA: cmd_o.rd_sel = oapm_pkg::RD_BEST;
      oapm_pkg::ST_SWAP_RB: begin
        cmd_o.rd_sel = oapm_pkg::RD_LAST;
        cmd_o.swap_latch = 1'b1;
      end
      oapm_pkg::ST_SWAP_WA: cmd_o.wr_sel = oapm_pkg::WR_A;
      oapm_pkg::ST_SWAP_WB: begin
        cmd_o.wr_sel = oapm_pkg::WR_B;
        cmd_o.live_dec = 1'b1;
        cmd_o.j_inc = 1'b1;
      end
      oapm_pkg::ST_FINISH: cmd_o.finish = !sts_i.out_full;
      default: cmd_o.in_ready = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oapm_datapath.sv =====
`default_nettype none
module oapm_datapath #(
  parameter int unsigned ANCHORS  = 128,
  parameter int unsigned POS_BITS = 24
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  oapm_pkg::cmd_t                      cmd_i,
  output oapm_pkg::status_t                   sts_o,
  input  wire  [oapm_pkg::EPS2_W-1:0]         eps2_i,
  input  wire                                 in_valid_i,
  input  wire  [119:0]                        in_data_i,
  input  wire                                 in_last_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [15:0]                         out_data_o,
  output logic                                out_last_o
);

  localparam int unsigned IDX_W = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
  localparam int unsigned CNT_W = $clog2(ANCHORS + 1);
  localparam int unsigned OW = oapm_pkg::ORIG_W;
  localparam int unsigned NW = oapm_pkg::NORM_W;
  localparam int unsigned NZ_LO = OW;
  localparam int unsigned NY_LO = OW + NW;
  localparam int unsigned NX_LO = OW + 2 * NW;
  localparam int unsigned PZ_LO = OW + 3 * NW;
  localparam int unsigned PY_LO = PZ_LO + POS_BITS;
  localparam int unsigned PX_LO = PZ_LO + 2 * POS_BITS;
  localparam int unsigned WORD_W = PZ_LO + 3 * POS_BITS;
  localparam int unsigned DW = POS_BITS + 1;

  // Anchor store and its registered read port.
  logic [WORD_W-1:0] mem [ANCHORS];
  logic [WORD_W-1:0] rdata_q;
  logic [IDX_W-1:0]  raddr, waddr;
  logic [WORD_W-1:0] wdata;
  logic              wen;

  // Counters and scan state.
  logic [CNT_W-1:0] count_q, count_d, live_q, j_q, i_q;
  logic [CNT_W-1:0] live_m1, j_p1;
  logic [WORD_W-1:0] jword_q, swap_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [OW-1:0]    best_orig_q;
  logic [oapm_pkg::DIST_W-1:0] best_q;
  logic             found_q;
  logic             load_acc;

  // Pending pair and output register.
  logic          pend_v_q;
  logic [OW-1:0] pend_a_q, pend_b_q;
  logic          out_v_q, out_pv_q, out_last_q;
  logic [OW-1:0] out_a_q, out_b_q;

  assign live_m1  = live_q - CNT_W'(1);
  assign j_p1     = j_q + CNT_W'(1);
  assign load_acc = cmd_i.in_ready && in_valid_i;
  assign count_d  = (count_q < CNT_W'(ANCHORS)) ? count_q + CNT_W'(1) : count_q;

  // Read address select.
  always_comb begin
    unique case (cmd_i.rd_sel)
      oapm_pkg::RD_J:    raddr = j_q[IDX_W-1:0];
      oapm_pkg::RD_I:    raddr = i_q[IDX_W-1:0];
      oapm_pkg::RD_BEST: raddr = best_idx_q;
      oapm_pkg::RD_LAST: raddr = live_m1[IDX_W-1:0];
      default:           raddr = j_q[IDX_W-1:0];
    endcase
  end

  // Write select: anchor load, or one half of a slot swap.
  logic [31:0] ex_x, ex_y, ex_z;
  assign ex_x = {8'd0, in_data_i[23:0]};
  assign ex_y = {8'd0, in_data_i[47:24]};
  assign ex_z = {8'd0, in_data_i[71:48]};
  always_comb begin
    wen   = 1'b0;
    waddr = count_q[IDX_W-1:0];
    wdata = {ex_x[POS_BITS-1:0], ex_y[POS_BITS-1:0], ex_z[POS_BITS-1:0],
             in_data_i[87:72], in_data_i[103:88], in_data_i[119:104],
             OW'(count_q)};
    unique case (cmd_i.wr_sel)
      oapm_pkg::WR_LOAD: wen = load_acc && (count_q < CNT_W'(ANCHORS));
      oapm_pkg::WR_A: begin
        wen   = 1'b1;
        waddr = best_idx_q;
        wdata = rdata_q;
      end
      oapm_pkg::WR_B: begin
        wen   = 1'b1;
        waddr = live_m1[IDX_W-1:0];
        wdata = swap_q;
      end
      default: wen = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Stage 1: differences against slot j and normal products.
  logic v1_q, v2_q, v3_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  logic [OW-1:0]    org2_q, org3_q;
  logic signed [POS_BITS-1:0] cx, cy, cz, jx, jy, jz;
  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]    ax, ay, az;
  logic [32:0]      ex_ax, ex_ay, ex_az;
  logic [29:0]      sa_x_q, sa_y_q, sa_z_q;
  logic             large2_q, large3_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [NW-1:0] cnx, cny, cnz, jnx, jny, jnz;

  assign cx  = rdata_q[PX_LO +: POS_BITS];
  assign cy  = rdata_q[PY_LO +: POS_BITS];
  assign cz  = rdata_q[PZ_LO +: POS_BITS];
  assign jx  = jword_q[PX_LO +: POS_BITS];
  assign jy  = jword_q[PY_LO +: POS_BITS];
  assign jz  = jword_q[PZ_LO +: POS_BITS];
  assign cnx = rdata_q[NX_LO +: NW];
  assign cny = rdata_q[NY_LO +: NW];
  assign cnz = rdata_q[NZ_LO +: NW];
  assign jnx = jword_q[NX_LO +: NW];
  assign jny = jword_q[NY_LO +: NW];
  assign jnz = jword_q[NZ_LO +: NW];
  assign dx  = DW'(cx) - DW'(jx);
  assign dy  = DW'(cy) - DW'(jy);
  assign dz  = DW'(cz) - DW'(jz);
  assign ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign az  = dz[DW-1] ? DW'(-dz) : DW'(dz);
  assign ex_ax = 33'(ax);
  assign ex_ay = 33'(ay);
  assign ex_az = 33'(az);

  // Stage 2 and 3 signals.
  logic [59:0] sq_x_q, sq_y_q, sq_z_q;
  logic        opp3_q;
  logic signed [33:0] dot_sum;
  logic [oapm_pkg::DIST_W-1:0] cand_dist;

  assign dot_sum = 34'(px_q) + 34'(py_q) + 34'(pz_q);
  assign cand_dist = large3_q ? oapm_pkg::DIST_CAP
                   : oapm_pkg::DIST_W'(sq_x_q) + oapm_pkg::DIST_W'(sq_y_q)
                     + oapm_pkg::DIST_W'(sq_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q   <= i_q[IDX_W-1:0];
    idx2_q   <= idx1_q;
    org2_q   <= rdata_q[OW-1:0];
    sa_x_q   <= ex_ax[29:0];
    sa_y_q   <= ex_ay[29:0];
    sa_z_q   <= ex_az[29:0];
    large2_q <= |{ex_ax[32:30], ex_ay[32:30], ex_az[32:30]};
    px_q     <= cnx * jnx;
    py_q     <= cny * jny;
    pz_q     <= cnz * jnz;
    idx3_q   <= idx2_q;
    org3_q   <= org2_q;
    large3_q <= large2_q;
    sq_x_q   <= sa_x_q * sa_x_q;
    sq_y_q   <= sa_y_q * sa_y_q;
    sq_z_q   <= sa_z_q * sa_z_q;
    opp3_q   <= dot_sum < oapm_pkg::DOT_NEG_LIMIT;
  end

  // Slot j capture and swap staging.
  always_ff @(posedge clk_i) begin
    if (cmd_i.j_latch) jword_q <= rdata_q;
    if (cmd_i.swap_latch) swap_q <= rdata_q;
  end

  // Best candidate tracking: first smallest distance wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.j_latch) begin
      found_q <= 1'b0;
    end else if (v3_q && opp3_q && (!found_q || cand_dist < best_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && opp3_q && (!found_q || cand_dist < best_q)) begin
      best_q      <= cand_dist;
      best_idx_q  <= idx3_q;
      best_orig_q <= org3_q;
    end
  end

  // Counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      live_q  <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      if (load_acc) count_q <= count_d;
      if (cmd_i.finish) count_q <= '0;
      if (load_acc && in_last_i) begin
        live_q <= count_d;
        j_q    <= '0;
      end else begin
        if (cmd_i.live_dec) live_q <= live_m1;
        if (cmd_i.j_inc) j_q <= j_p1;
      end
      if (cmd_i.j_latch) begin
        i_q <= j_p1;
      end else if (cmd_i.scan_issue) begin
        i_q <= i_q + CNT_W'(1);
      end
    end
  end

  // Pending pair and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.take_pair) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pair) begin
      pend_a_q   <= jword_q[OW-1:0];
      pend_b_q   <= best_orig_q;
      out_a_q    <= pend_a_q;
      out_b_q    <= pend_b_q;
      out_pv_q   <= 1'b1;
      out_last_q <= 1'b0;
    end
    if (cmd_i.finish) begin
      out_a_q    <= pend_v_q ? pend_a_q : '0;
      out_b_q    <= pend_v_q ? pend_b_q : '0;
      out_pv_q   <= pend_v_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = {1'b0, out_pv_q, out_b_q, out_a_q};
  assign out_last_o  = out_last_q;

  // Status back to the controller.
  assign sts_o.in_last_acc = load_acc && in_last_i;
  assign sts_o.j_end       = j_p1 >= live_q;
  assign sts_o.i_end       = i_q == live_m1;
  assign sts_o.pipe_busy   = v1_q || v2_q || v3_q;
  assign sts_o.hit         = found_q && (best_q < oapm_pkg::DIST_W'(eps2_i));
  assign sts_o.out_full    = out_v_q;

`ifndef SYNTHESIS
  // A scan read never goes past the live range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> (i_q < live_q) && (i_q > j_q))
    else $error("scan read outside live range");
  // A taken partner always lies after the scanning slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_pair |-> (CNT_W'(best_idx_q) > j_q))
    else $error("partner not after scanning slot");
  // A pair is taken, or the final word written, only with room in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_pair || cmd_i.finish) |-> !out_v_q)
    else $error("output register overwritten");
`endif

endmodule
`default_nettype wire
